// ===== design/rlt_pkg.sv =====
// shared types and codes for the refcounted lock table
package rlt_pkg;
   localparam logic [2:0] OP_ACQUIRE = 3'd0;
   localparam logic [2:0] OP_ROLLBACK = 3'd1;
   localparam logic [2:0] OP_RELEASE = 3'd2;
   localparam logic [2:0] OP_HAS = 3'd3;
   localparam logic [2:0] OP_LIST = 3'd4;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_BAD_ARG = 3'd1;
   localparam logic [2:0] ST_MISSING = 3'd2;
   localparam logic [2:0] ST_FULL = 3'd3;
   localparam logic [2:0] ST_SATURATED = 3'd4;

   localparam logic [15:0] CNT_MAX = 16'hFFFF;

   typedef struct packed {
      logic [31:0] owner;
      logic [63:0] table_ref;
      logic [3:0] mode;
      logic [15:0] count;
   } entry_type;

   // command broadcast to every cell at once
   typedef struct packed {
      logic inc;    // bump count of the matching cell
      logic dec;    // lower count of the matching cell, drop at zero
      logic drop_owner; // first cell of the owner leaves, the rest shift left
      logic append; // first empty cell takes the new entry
      logic shift;  // shift the list left by one (list walk)
   } cmd_type;

   function automatic logic mode_ok(input logic [3:0] m);
      return (m == 4'd4) || (m == 4'd6) || (m == 4'd8) || (m == 4'd12) || (m == 4'd14);
   endfunction
endpackage

// ===== design/refcounted_lock_table_unit.sv =====
// top level of the refcounted lock table
//
// one request channel (req_*) and one response channel (rsp_*), both with
// valid and stall. a request is taken when req_valid is high and req_stall
// is low; a response is taken when rsp_valid is high and rsp_stall is low.
// the table is a chain of ENTRIES cells kept packed from cell 0 in
// acquisition order. a request that fails the argument check gets its
// response in the next cycle. acquire, rollback and has lock go through
// the evaluate state and then the response state, which registers their
// response. release all removes one matching entry per cycle through the
// chain and responds once the owner has no entry left; list locks walks
// the whole table by rotating it through the chain, pausing while a
// response is stalled, and gives one response per matching entry (last one
// flagged by rsp_last), or one empty response if there is none. rollback
// that empties an entry compacts the chain in one shift.
// reset clears every valid bit at once; no clearing pass is needed.
// while rsp_stall is high the response register holds and the unit waits,
// taking no new request until the pending response is gone.
// only one request is worked on at a time.
module refcounted_lock_table_unit #(
   parameter int ENTRIES = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [2:0] req_opcode,
   input  logic [31:0] req_owner,
   input  logic [63:0] req_table_ref,
   input  logic [3:0] req_mode,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [2:0] rsp_status,
   output logic rsp_need_new_lock,
   output logic rsp_owner_holds,
   output logic [21:0] rsp_released_total,
   output logic rsp_snap_present,
   output logic [63:0] rsp_snap_table,
   output logic [3:0] rsp_snap_mode,
   output logic [15:0] rsp_snap_count,
   output logic rsp_last
);
   import rlt_pkg::*;

   localparam int CW = $clog2(ENTRIES + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EVAL = 3'd1;
   localparam logic [2:0] S_REL = 3'd2;
   localparam logic [2:0] S_LIST = 3'd3;
   localparam logic [2:0] S_RESP = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [2:0] op_ff;
   entry_type key_ff;
   logic [CW-1:0] walk_ff, walk_in;
   logic [21:0] total_ff, total_in;

   // pending list entry waiting for the next match (to mark last)
   logic pend_ff, pend_in;
   entry_type pend_e_ff, pend_e_in;

   cmd_type cmd;
   logic [ENTRIES-1:0] c_valid, c_hit, c_own, c_drop;
   entry_type c_entry [0:ENTRIES-1];
   logic [ENTRIES:0] hit_chain, drop_chain;

   // response register
   logic rv_ff, rv_in;
   logic [2:0] r_status_ff, r_status_in;
   logic r_need_ff, r_need_in, r_holds_ff, r_holds_in, r_pres_ff, r_pres_in;
   logic r_last_ff, r_last_in;
   logic [21:0] r_total_ff, r_total_in;
   entry_type r_e_ff, r_e_in;

   entry_type key_c;
   logic any_hit, any_own, full, hit_sat;
   logic [15:0] hit_count;

   assign hit_chain[0] = 1'b0;
   assign drop_chain[0] = 1'b0;

   genvar g;
   generate
      for (g = 0; g < ENTRIES; g++) begin : g_cell
         entry_type rin;
         logic rv;
         logic pv;
         assign pv = (g == 0) ? 1'b1 : c_valid[(g == 0) ? 0 : g - 1];
         if (g + 1 < ENTRIES) begin : g_r
            assign rin = c_entry[g + 1];
            assign rv = c_valid[g + 1];
         end else begin : g_last
            // list walk rotates the last cell from cell 0
            assign rin = c_entry[0];
            assign rv = cmd.shift ? c_valid[0] : 1'b0;
         end
         assign hit_chain[g + 1] = hit_chain[g] | c_hit[g];
         assign drop_chain[g + 1] = drop_chain[g] | c_drop[g];
         rlt_cell u_cell (
            .clock(clock), .reset(reset), .cmd(cmd), .key(key_ff),
            .prev_valid(pv), .hit_before(hit_chain[g]), .drop_before(drop_chain[g]),
            .right_in(rin), .right_valid(rv),
            .valid(c_valid[g]), .entry(c_entry[g]),
            .hit(c_hit[g]), .own_hit(c_own[g]), .drop(c_drop[g])
         );
      end
   endgenerate

   assign any_hit = hit_chain[ENTRIES];
   assign any_own = |c_own;
   assign full = c_valid[ENTRIES-1];

   always_comb begin
      hit_count = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (c_hit[i] && !hit_chain[i]) hit_count = c_entry[i].count;
      end
      hit_sat = (hit_count == CNT_MAX);
   end

   // count of the first owner entry (release all takes one per cycle)
   logic [15:0] own_count;
   logic [ENTRIES:0] own_chain;
   assign own_chain[0] = 1'b0;
   generate
      for (g = 0; g < ENTRIES; g++) begin : g_own
         assign own_chain[g + 1] = own_chain[g] | c_own[g];
      end
   endgenerate
   always_comb begin
      own_count = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (c_own[i] && !own_chain[i]) own_count = c_entry[i].count;
      end
   end

   assign req_stall = (state_ff != S_IDLE) || rv_ff;
   assign key_c = '{owner: req_owner, table_ref: req_table_ref, mode: req_mode, count: 16'd1};

   always_comb begin
      state_in = state_ff;
      walk_in = walk_ff;
      total_in = total_ff;
      pend_in = pend_ff;
      pend_e_in = pend_e_ff;
      cmd = '0;
      rv_in = rv_ff && rsp_stall;
      r_status_in = r_status_ff;
      r_need_in = r_need_ff;
      r_holds_in = r_holds_ff;
      r_pres_in = r_pres_ff;
      r_last_in = r_last_ff;
      r_total_in = r_total_ff;
      r_e_in = r_e_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               walk_in = '0;
               total_in = '0;
               pend_in = 1'b0;
               if (req_opcode > OP_LIST || req_owner == 32'd0 ||
                   (req_opcode <= OP_ROLLBACK &&
                    (req_table_ref == 64'hFFFF_FFFF_FFFF_FFFF || !mode_ok(req_mode)))) begin
                  rv_in = 1'b1;
                  r_status_in = ST_BAD_ARG;
                  r_need_in = 1'b0; r_holds_in = 1'b0; r_pres_in = 1'b0;
                  r_total_in = '0; r_e_in = '0; r_last_in = 1'b1;
               end else begin
                  state_in = S_EVAL;
               end
            end
         end
         S_EVAL: begin
            r_need_in = 1'b0; r_holds_in = 1'b0; r_pres_in = 1'b0;
            r_total_in = '0; r_e_in = '0; r_last_in = 1'b1; r_status_in = ST_OK;
            state_in = S_RESP;
            unique case (op_ff)
               OP_ACQUIRE: begin
                  if (any_hit) begin
                     if (hit_sat) r_status_in = ST_SATURATED;
                     else cmd.inc = 1'b1;
                  end else if (full) begin
                     r_status_in = ST_FULL;
                  end else begin
                     cmd.append = 1'b1;
                     r_need_in = 1'b1;
                  end
               end
               OP_ROLLBACK: begin
                  if (any_hit) cmd.dec = 1'b1;
                  else r_status_in = ST_MISSING;
               end
               OP_RELEASE: state_in = S_REL;
               OP_HAS: r_holds_in = any_own;
               default: state_in = S_LIST;
            endcase
         end
         S_REL: begin
            if (any_own) begin
               total_in = total_ff + 22'(own_count);
            end else begin
               r_total_in = total_ff;
               state_in = S_RESP;
            end
         end
         S_LIST: begin
            // examine cell 0, then rotate the chain by one
            if (!rv_ff || !rsp_stall) begin
               if (walk_ff == CW'(ENTRIES)) begin
                  state_in = S_RESP;
                  r_status_in = ST_OK; r_need_in = 1'b0; r_holds_in = 1'b0;
                  r_total_in = '0; r_last_in = 1'b1;
                  if (pend_ff) begin
                     r_pres_in = 1'b1; r_e_in = pend_e_ff;
                  end else begin
                     r_pres_in = 1'b0; r_e_in = '0;
                  end
               end else begin
                  cmd.shift = 1'b1;
                  walk_in = walk_ff + CW'(1);
                  if (c_own[0]) begin
                     if (pend_ff) begin
                        rv_in = 1'b1;
                        r_status_in = ST_OK; r_need_in = 1'b0; r_holds_in = 1'b0;
                        r_total_in = '0; r_pres_in = 1'b1; r_e_in = pend_e_ff;
                        r_last_in = 1'b0;
                     end
                     pend_in = 1'b1;
                     pend_e_in = c_entry[0];
                  end
               end
            end
         end
         S_RESP: begin
            if (!rv_ff || !rsp_stall) begin
               rv_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_REL && any_own) cmd.drop_owner = 1'b1;
   end

   // release all: every owner cell drops, but the chain only shifts by one,
   // so exactly the first owner entry leaves per cycle and own_count is
   // the count that goes with it

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
         pend_ff <= pend_in;
      end
      if (state_ff == S_IDLE && req_valid && !req_stall) begin
         op_ff <= req_opcode;
         key_ff <= key_c;
      end
      walk_ff <= walk_in;
      total_ff <= total_in;
      pend_e_ff <= pend_e_in;
      r_status_ff <= r_status_in;
      r_need_ff <= r_need_in;
      r_holds_ff <= r_holds_in;
      r_pres_ff <= r_pres_in;
      r_last_ff <= r_last_in;
      r_total_ff <= r_total_in;
      r_e_ff <= r_e_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_status = r_status_ff;
   assign rsp_need_new_lock = r_need_ff;
   assign rsp_owner_holds = r_holds_ff;
   assign rsp_released_total = r_total_ff;
   assign rsp_snap_present = r_pres_ff;
   assign rsp_snap_table = r_e_ff.table_ref;
   assign rsp_snap_mode = r_e_ff.mode;
   assign rsp_snap_count = r_e_ff.count;
   assign rsp_last = r_last_ff;

   // table stays packed outside the list walk: valid bits form one run from cell 0
   a_packed: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_LIST) |-> ((c_valid & (c_valid + 1'b1)) == '0))
      else $error("table not packed");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall)
      else $error("request taken while busy");
   a_resp_hold: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rsp_stall) |=> rv_ff)
      else $error("response lost");
endmodule

// ===== design/rlt_cell.sv =====
// one slot of the lock table chain
module rlt_cell (
   input  logic clock,
   input  logic reset,
   input  rlt_pkg::cmd_type cmd,
   input  rlt_pkg::entry_type key,
   input  logic prev_valid,      // valid bit of the cell to the left
   input  logic hit_before,      // some cell to the left matches the key
   input  logic drop_before,     // some cell to the left drops this cycle
   input  rlt_pkg::entry_type right_in, // cell one to the right
   input  logic right_valid,
   output logic valid,
   output rlt_pkg::entry_type entry,
   output logic hit,             // full match of owner, table and mode
   output logic own_hit,
   output logic drop             // drop condition holds; only the first such cell leaves
);
   import rlt_pkg::*;

   logic valid_ff, valid_in;
   entry_type entry_ff, entry_in;

   assign own_hit = valid_ff && (entry_ff.owner == key.owner);
   assign hit = own_hit && (entry_ff.table_ref == key.table_ref) && (entry_ff.mode == key.mode);
   assign drop = (cmd.dec && hit && !hit_before && (entry_ff.count == 16'd1)) ||
                 (cmd.drop_owner && own_hit);

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (cmd.inc && hit && !hit_before) begin
         entry_in.count = entry_ff.count + 16'd1;
      end else if (cmd.dec && hit && !hit_before && !drop) begin
         entry_in.count = entry_ff.count - 16'd1;
      end
      if (cmd.append && !valid_ff && prev_valid) begin
         valid_in = 1'b1;
         entry_in = key;
      end
      // single drop: compaction moves the right neighbor in
      if (cmd.dec && (drop_before || drop)) begin
         valid_in = right_valid;
         entry_in = right_in;
      end
      if (cmd.shift) begin
         valid_in = right_valid;
         entry_in = right_in;
      end
      // release all: one-step compaction by at most one per cycle
      if (cmd.drop_owner && (drop_before || drop)) begin
         valid_in = right_valid;
         entry_in = right_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

   assign valid = valid_ff;
   assign entry = entry_ff;
endmodule

// ===== test/tb_refcounted_lock_table_unit.sv =====
// testbench for the refcounted lock table: directed and random requests checked against a model
`timescale 1ns / 1ps

module tb_refcounted_lock_table_unit;
   import rlt_pkg::*;

   localparam int SLOTS = 64;
   localparam int IDLE_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_opcode = '0;
   logic [31:0] req_owner = '0;
   logic [63:0] req_table_ref = '0;
   logic [3:0] req_mode = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [2:0] rsp_status;
   logic rsp_need_new_lock;
   logic rsp_owner_holds;
   logic [21:0] rsp_released_total;
   logic rsp_snap_present;
   logic [63:0] rsp_snap_table;
   logic [3:0] rsp_snap_mode;
   logic [15:0] rsp_snap_count;
   logic rsp_last;

   typedef struct packed {
      logic [2:0] status;
      logic need;
      logic holds;
      logic [21:0] total;
      logic present;
      logic [63:0] tab;
      logic [3:0] mode;
      logic [15:0] count;
      logic last;
   } answer_type;

   // predicted lock table, packed from slot 0
   int unsigned held;
   logic [31:0] lk_owner[SLOTS];
   logic [63:0] lk_table[SLOTS];
   logic [3:0] lk_mode[SLOTS];
   logic [15:0] lk_count[SLOTS];

   answer_type pending_answers[$];
   int mismatches = 0;
   int idle_cycles = 0;
   bit quiet = 1'b0;        // no random idling in the last part
   bit hold_rsp = 1'b0;     // long receiver hold-off request
   int rsp_hold_len = 0;
   int stall_left = 0;      // remaining cycles of a receiver stall burst

   refcounted_lock_table_unit i_dut (.*);

   always #2 clock = ~clock;

   // watchdog: cycles with no handshake on either side
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic bit mode_valid(logic [3:0] m);
      return m == 4'd4 || m == 4'd6 || m == 4'd8 || m == 4'd12 || m == 4'd14;
   endfunction

   function automatic answer_type plain(logic [2:0] st);
      answer_type a;
      a = '0;
      a.status = st;
      a.last = 1'b1;
      return a;
   endfunction

   // append one expected response
   function automatic void queue_answer(answer_type a);
      pending_answers = {pending_answers, a};
   endfunction

   function automatic void drop_slot(int idx);
      for (int i = idx; i + 1 < SLOTS; i++) begin
         lk_owner[i] = lk_owner[i + 1];
         lk_table[i] = lk_table[i + 1];
         lk_mode[i] = lk_mode[i + 1];
         lk_count[i] = lk_count[i + 1];
      end
      held--;
   endfunction

   // apply one request to the predicted table, queue the responses it causes
   function automatic void predict_lock_op(logic [2:0] op, logic [31:0] own,
                                           logic [63:0] tab, logic [3:0] md);
      int idx;
      int i;
      int hits;
      answer_type a;
      logic [21:0] sum;
      idx = -1;
      hits = 0;
      sum = '0;
      if (op > OP_LIST || own == 0 ||
          (op <= OP_ROLLBACK && (tab == '1 || !mode_valid(md)))) begin
         queue_answer(plain(ST_BAD_ARG));
         return;
      end
      for (i = 0; i < held; i++)
         if (idx < 0 && lk_owner[i] == own && lk_table[i] == tab && lk_mode[i] == md)
            idx = i;
      case (op)
         OP_ACQUIRE: begin
            if (idx >= 0) begin
               if (lk_count[idx] == CNT_MAX) queue_answer(plain(ST_SATURATED));
               else begin
                  lk_count[idx]++;
                  queue_answer(plain(ST_OK));
               end
            end else if (held >= SLOTS) begin
               queue_answer(plain(ST_FULL));
            end else begin
               lk_owner[held] = own;
               lk_table[held] = tab;
               lk_mode[held] = md;
               lk_count[held] = 16'd1;
               held++;
               a = plain(ST_OK);
               a.need = 1'b1;
               queue_answer(a);
            end
         end
         OP_ROLLBACK: begin
            if (idx < 0) queue_answer(plain(ST_MISSING));
            else begin
               lk_count[idx]--;
               if (lk_count[idx] == 0) drop_slot(idx);
               queue_answer(plain(ST_OK));
            end
         end
         OP_RELEASE: begin
            i = 0;
            while (i < held) begin
               if (lk_owner[i] == own) begin
                  sum += 22'(lk_count[i]);
                  drop_slot(i);
               end else i++;
            end
            a = plain(ST_OK);
            a.total = sum;
            queue_answer(a);
         end
         OP_HAS: begin
            a = plain(ST_OK);
            for (i = 0; i < held; i++)
               if (lk_owner[i] == own) a.holds = 1'b1;
            queue_answer(a);
         end
         default: begin
            for (i = 0; i < held; i++)
               if (lk_owner[i] == own) begin
                  a = '0;
                  a.present = 1'b1;
                  a.tab = lk_table[i];
                  a.mode = lk_mode[i];
                  a.count = lk_count[i];
                  queue_answer(a);
                  hits++;
               end
            if (hits == 0) queue_answer(plain(ST_OK));
            else pending_answers[$].last = 1'b1;
         end
      endcase
   endfunction

   // receiver: random stall bursts, or a long hold-off when asked
   always @(posedge clock) begin
      if (hold_rsp && rsp_hold_len < 400) begin
         rsp_stall <= 1'b1;
         rsp_hold_len <= rsp_hold_len + 1;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 8);
      end else
         rsp_stall <= 1'b0;
   end

   // response checker
   always @(posedge clock) begin
      answer_type got;
      answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_status, rsp_need_new_lock, rsp_owner_holds, rsp_released_total,
                rsp_snap_present, rsp_snap_table, rsp_snap_mode, rsp_snap_count,
                rsp_last};
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
         end else begin
            want = pending_answers.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h actual %h", want, got);
            end
         end
      end
   end

   // send one request; random gap before it unless in the quiet part
   task automatic send_request(logic [2:0] op, logic [31:0] own, logic [63:0] tab,
                               logic [3:0] md);
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_owner <= own;
      req_table_ref <= tab;
      req_mode <= md;
      predict_lock_op(op, own, tab, md);
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   function automatic logic [3:0] good_mode();
      case ($urandom_range(0, 4))
         0: return 4'd4;
         1: return 4'd6;
         2: return 4'd8;
         3: return 4'd12;
         default: return 4'd14;
      endcase
   endfunction

   task automatic test_directed();
      send_request(OP_LIST, 32'd1, '0, 4'd4);             // empty list
      send_request(OP_HAS, 32'd1, '0, 4'd4);
      send_request(OP_RELEASE, 32'd1, '0, 4'd4);          // nothing to free
      send_request(OP_ROLLBACK, 32'd1, 64'd5, 4'd4);      // missing entry
      send_request(OP_ACQUIRE, 32'd0, 64'd5, 4'd4);       // invalid owner
      send_request(OP_ACQUIRE, 32'd1, '1, 4'd4);          // invalid table
      send_request(OP_ACQUIRE, 32'd1, 64'd5, 4'd5);       // invalid mode
      send_request(3'd5, 32'd1, 64'd5, 4'd4);             // unknown opcodes
      send_request(3'd7, '1, 64'd5, 4'd4);
      send_request(OP_HAS, 32'd0, '0, 4'd0);
      send_request(OP_ACQUIRE, '1, 64'hFFFF_FFFF_FFFF_FFFE, 4'd14);
      send_request(OP_ACQUIRE, '1, 64'hFFFF_FFFF_FFFF_FFFE, 4'd14);
      send_request(OP_ACQUIRE, '1, 64'd0, 4'd4);
      send_request(OP_ACQUIRE, 32'd1, 64'd0, 4'd6);
      send_request(OP_ACQUIRE, '1, 64'd0, 4'd8);
      send_request(OP_ACQUIRE, '1, 64'd7, 4'd12);
      send_request(OP_LIST, '1, '0, 4'd0);
      send_request(OP_HAS, '1, '0, 4'd0);
      send_request(OP_ROLLBACK, '1, 64'd0, 4'd4);         // empties, compacts
      send_request(OP_ROLLBACK, '1, 64'hFFFF_FFFF_FFFF_FFFE, 4'd14);
      send_request(OP_LIST, '1, '0, 4'd15);
      send_request(OP_RELEASE, '1, '0, 4'd0);
      send_request(OP_LIST, 32'd1, '0, 4'd0);
      send_request(OP_RELEASE, 32'd1, '0, 4'd0);
   endtask

   // table full: fill all slots, then one more distinct acquire
   task automatic test_table_full();
      for (int i = 0; i < SLOTS; i++)
         send_request(OP_ACQUIRE, 32'd9 + (i % 3), 64'd100 + i, good_mode());
      send_request(OP_ACQUIRE, 32'd2, 64'd1, 4'd4);
      send_request(OP_LIST, 32'd10, '0, 4'd0);
      for (int o = 9; o < 12; o++) send_request(OP_RELEASE, o, '0, 4'd0);
   endtask

   // receiver holds off long while the sender keeps offering
   task automatic test_backpressure();
      rsp_hold_len = 0;
      hold_rsp = 1'b1;
      for (int i = 0; i < 12; i++)
         send_request(OP_ACQUIRE, 32'd3, 64'($urandom_range(0, 3)), good_mode());
      hold_rsp = 1'b0;
      wait_drained();                       // sender pause until all is in
      send_request(OP_RELEASE, 32'd3, '0, 4'd0);
   endtask

   // random traffic over a few owners and tables, plus some noise
   task automatic test_random(int n);
      logic [2:0] op;
      logic [31:0] own;
      logic [63:0] tab;
      logic [3:0] md;
      for (int i = 0; i < n; i++) begin
         if (i > n - 60) quiet = 1'b1;
         own = $urandom_range(1, 4);
         tab = 64'($urandom_range(0, 5));
         md = good_mode();
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7: op = OP_ACQUIRE;
            8, 9, 10, 11: op = OP_ROLLBACK;
            12: op = OP_RELEASE;
            13, 14: op = OP_HAS;
            15, 16: op = OP_LIST;
            default: begin
               op = 3'($urandom_range(0, 7));
               own = $urandom_range(0, 3) == 0 ? 32'd0 : $urandom;
               tab = {$urandom, $urandom};
               md = 4'($urandom_range(0, 15));
            end
         endcase
         send_request(op, own, tab, md);
      end
   endtask

   initial begin
      held = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_table_full();
      test_backpressure();
      test_random(265);
      wait_drained();
      repeat (100) @(posedge clock);
      if (mismatches == 0 && pending_answers.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule

// ===== refcounted_lock_table_unit.f =====
design/rlt_pkg.sv
design/rlt_cell.sv
design/refcounted_lock_table_unit.sv
test/tb_refcounted_lock_table_unit.sv
